>>> hw/rtl/tks_pkg.sv
// Shared types and constants for the top-k row selector.
package tks_pkg;

    localparam int KEY_PORT_W  = 64;
    localparam int TAG_PORT_W  = 32;
    localparam int RANK_W      = 4;
    localparam int LIMIT_W     = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_DESC  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT = 1'd1;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op op;
        logic     descending;
        logic     none_beat;
    } t_cell_ctl;

endpackage

>>> hw/rtl/top_k_row_selector.sv
// Top-k row selector: sorted insertion chain with a flush sequencer.
// Offer: accepted when idle, no result; a new request may follow next cycle.
// Flush: the sequencer enters the flush state, then results are registered one per cycle
// while the receiver does not stall, as the output drains the chain head; input stalls
// until the last result, or the empty-flush result, is registered.
// Reset (synchronous, active low) clears count, sequencer and output valid and sets config to its reset values;
// stored rows are not cleared, the count of zero makes them unread.
module top_k_row_selector #(
    parameter int STORE_DEPTH = 16,
    parameter int KEY_BITS    = 64,
    parameter int TAG_BITS    = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tks_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tks_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_cmd,
    input  logic [tks_pkg::KEY_PORT_W-1:0]   i_row_key,
    input  logic [tks_pkg::TAG_PORT_W-1:0]   i_row_tag,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [tks_pkg::KEY_PORT_W-1:0]   o_out_key,
    output logic [tks_pkg::TAG_PORT_W-1:0]   o_out_tag,
    output logic [tks_pkg::RANK_W-1:0]       o_out_rank,
    output logic                             o_out_last,
    output logic                             o_none_kept
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > tks_pkg::LIMIT_W) ? CNT_W : tks_pkg::LIMIT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(STORE_DEPTH);

    tks_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [CNT_W-1:0]              r_rem, n_rem;
    logic [tks_pkg::RANK_W-1:0]    r_rank, n_rank;
    logic                          r_desc;
    logic [tks_pkg::LIMIT_W-1:0]   r_limit;
    logic                          r_out_valid, n_out_valid;
    logic [tks_pkg::KEY_PORT_W-1:0] r_out_key, n_out_key;
    logic [tks_pkg::TAG_PORT_W-1:0] r_out_tag, n_out_tag;
    logic [tks_pkg::RANK_W-1:0]    r_out_rank, n_out_rank;
    logic                          r_out_last, n_out_last;
    logic                          r_none, n_none;

    logic [CMP_W-1:0]  w_lim_ext;
    logic [CNT_W-1:0]  w_lim;
    logic              w_full;
    logic [CNT_W-1:0]  w_n_eff;
    logic              w_last_better;
    logic              w_do_ins;
    logic              w_in_acc;
    logic              w_offer;
    logic              w_flush;
    logic              w_load;
    logic [KEY_BITS-1:0] w_new_key;
    logic [TAG_BITS-1:0] w_new_tag;
    tks_pkg::t_cell_ctl  w_ctl;

    logic [KEY_BITS-1:0]    w_key [STORE_DEPTH];
    logic [TAG_BITS-1:0]    w_tag [STORE_DEPTH];
    logic [STORE_DEPTH:0]   w_before;
    logic [STORE_DEPTH-1:0] w_last_beats;

    // limit clamped to 1..STORE_DEPTH
    always_comb begin
        w_lim_ext = CMP_W'(r_limit);
        if (w_lim_ext == '0) begin
            w_lim_ext = CMP_W'(1);
        end else if (w_lim_ext > DEPTH_C) begin
            w_lim_ext = DEPTH_C;
        end
    end
    assign w_lim = CNT_W'(w_lim_ext);

    assign w_new_key = KEY_BITS'(i_row_key);
    assign w_new_tag = TAG_BITS'(i_row_tag);

    assign w_full        = (r_cnt >= w_lim);
    assign w_n_eff       = w_full ? CNT_W'(r_cnt - 1'b1) : r_cnt;
    assign w_last_better = |w_last_beats;
    assign w_do_ins      = !w_full || w_last_better;

    assign o_stall  = (r_state != tks_pkg::ST_IDLE);
    assign w_in_acc = i_valid && !o_stall;
    assign w_offer  = w_in_acc && (i_cmd == tks_pkg::CMD_OFFER);
    assign w_flush  = w_in_acc && (i_cmd == tks_pkg::CMD_FLUSH);
    assign w_load   = (r_state == tks_pkg::ST_FLUSH) && (!r_out_valid || !i_stall);

    always_comb begin
        w_ctl.descending = r_desc;
        w_ctl.none_beat  = !w_before[STORE_DEPTH];
        if (w_offer && w_do_ins) begin
            w_ctl.op = tks_pkg::OP_INSERT;
        end else if (w_load && (r_rem != '0)) begin
            w_ctl.op = tks_pkg::OP_SHIFT;
        end else begin
            w_ctl.op = tks_pkg::OP_HOLD;
        end
    end

    assign w_before[0] = 1'b0;

    for (genvar gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
        logic [KEY_BITS-1:0] w_prev_key, w_next_key;
        logic [TAG_BITS-1:0] w_prev_tag, w_next_tag;

        if (gi == 0) begin : g_head
            assign w_prev_key = w_new_key;
            assign w_prev_tag = w_new_tag;
        end else begin : g_mid
            assign w_prev_key = w_key[gi-1];
            assign w_prev_tag = w_tag[gi-1];
        end
        if (gi == STORE_DEPTH - 1) begin : g_tail
            assign w_next_key = '0;
            assign w_next_tag = '0;
        end else begin : g_body
            assign w_next_key = w_key[gi+1];
            assign w_next_tag = w_tag[gi+1];
        end

        tks_cell #(
            .INDEX    (gi),
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_new_key    (w_new_key),
            .i_new_tag    (w_new_tag),
            .i_prev_key   (w_prev_key),
            .i_prev_tag   (w_prev_tag),
            .i_next_key   (w_next_key),
            .i_next_tag   (w_next_tag),
            .i_cnt        (r_cnt),
            .i_n_eff      (w_n_eff),
            .i_before     (w_before[gi]),
            .o_before     (w_before[gi+1]),
            .o_last_beats (w_last_beats[gi]),
            .o_key        (w_key[gi]),
            .o_tag        (w_tag[gi])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_rank      = r_rank;
        n_out_valid = r_out_valid && i_stall;
        n_out_key   = r_out_key;
        n_out_tag   = r_out_tag;
        n_out_rank  = r_out_rank;
        n_out_last  = r_out_last;
        n_none      = r_none;
        unique case (r_state)
            tks_pkg::ST_IDLE: begin
                if (w_offer && w_do_ins) begin
                    n_cnt = CNT_W'(w_n_eff + 1'b1);
                end else if (w_flush) begin
                    n_rem   = w_full ? w_lim : r_cnt;
                    n_rank  = '0;
                    n_cnt   = '0;
                    n_state = tks_pkg::ST_FLUSH;
                end
            end
            tks_pkg::ST_FLUSH: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    if (r_rem == '0) begin
                        // empty flush
                        n_out_key  = '0;
                        n_out_tag  = '0;
                        n_out_rank = '0;
                        n_out_last = 1'b1;
                        n_none     = 1'b1;
                        n_state    = tks_pkg::ST_IDLE;
                    end else begin
                        n_out_key  = tks_pkg::KEY_PORT_W'(w_key[0]);
                        n_out_tag  = tks_pkg::TAG_PORT_W'(w_tag[0]);
                        n_out_rank = r_rank;
                        n_out_last = (r_rem == CNT_W'(1));
                        n_none     = 1'b0;
                        n_rem      = CNT_W'(r_rem - 1'b1);
                        n_rank     = r_rank + 1'b1;
                        if (r_rem == CNT_W'(1)) begin
                            n_state = tks_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = tks_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tks_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_rank      <= '0;
            r_out_valid <= 1'b0;
            r_desc      <= 1'b0;
            r_limit     <= tks_pkg::LIMIT_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rem       <= n_rem;
            r_rank      <= n_rank;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    tks_pkg::REG_SORT_DESC:  r_desc  <= i_cfg_data[0];
                    tks_pkg::REG_KEEP_LIMIT: r_limit <= i_cfg_data[tks_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_key  <= n_out_key;
        r_out_tag  <= n_out_tag;
        r_out_rank <= n_out_rank;
        r_out_last <= n_out_last;
        r_none     <= n_none;
    end

    assign o_valid     = r_out_valid;
    assign o_out_key   = r_out_key;
    assign o_out_tag   = r_out_tag;
    assign o_out_rank  = r_out_rank;
    assign o_out_last  = r_out_last;
    assign o_none_kept = r_none;

endmodule

>>> hw/rtl/tks_cell.sv
// One slot of the sorted insertion chain: holds a key and tag, compares, shifts.
module tks_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_BITS = 64,
    parameter int TAG_BITS = 32,
    parameter int CNT_W    = 5
) (
    input  logic                 i_clk,
    input  tks_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_BITS-1:0]  i_new_key,
    input  logic [TAG_BITS-1:0]  i_new_tag,
    input  logic [KEY_BITS-1:0]  i_prev_key,
    input  logic [TAG_BITS-1:0]  i_prev_tag,
    input  logic [KEY_BITS-1:0]  i_next_key,
    input  logic [TAG_BITS-1:0]  i_next_tag,
    input  logic [CNT_W-1:0]     i_cnt,
    input  logic [CNT_W-1:0]     i_n_eff,
    input  logic                 i_before,
    output logic                 o_before,
    output logic                 o_last_beats,
    output logic [KEY_BITS-1:0]  o_key,
    output logic [TAG_BITS-1:0]  o_tag
);

    localparam logic [CNT_W-1:0] IDX     = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_P1  = CNT_W'(INDEX + 1);

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                w_beats;
    logic                w_hit;
    logic                w_at;
    logic                w_shift_in;

    // strictly better under the current direction
    assign w_beats = i_ctl.descending ? (i_new_key > r_key) : (i_new_key < r_key);
    assign w_hit   = w_beats && (IDX < i_n_eff);

    assign o_before     = i_before | w_hit;
    assign o_last_beats = w_beats && (i_cnt != '0) && (IDX_P1 == i_cnt);

    // first beaten slot takes the row; with no beaten slot it goes at the end
    assign w_at       = (w_hit && !i_before) || (i_ctl.none_beat && (IDX == i_n_eff));
    assign w_shift_in = i_before && (IDX <= i_n_eff);

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        unique case (i_ctl.op)
            tks_pkg::OP_INSERT: begin
                if (w_at) begin
                    n_key = i_new_key;
                    n_tag = i_new_tag;
                end else if (w_shift_in) begin
                    n_key = i_prev_key;
                    n_tag = i_prev_tag;
                end
            end
            tks_pkg::OP_SHIFT: begin
                n_key = i_next_key;
                n_tag = i_next_tag;
            end
            default: begin
                n_key = r_key;
                n_tag = r_tag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

>>> hw/rtl/tks_checker.sv
// Port-level checks for the top-k row selector, bound to the top level.
module tks_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_stall,
    input logic [tks_pkg::KEY_PORT_W-1:0]  i_out_key,
    input logic [tks_pkg::RANK_W-1:0]      i_out_rank,
    input logic                            i_out_last,
    input logic                            i_none_kept
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_none_kept |->
            i_out_last && (i_out_rank == '0) && (i_out_key == '0))
        else $error("empty flush result malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stall |=>
            i_out_valid && $stable(i_out_key) && $stable(i_out_rank))
        else $error("stalled result changed");

    // a taken non-final result is followed at once by the next rank
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_stall && !i_out_last |=>
            i_out_valid && !i_none_kept && (i_out_rank == ($past(i_out_rank) + 4'd1)))
        else $error("flush rank sequence broken");

endmodule

bind top_k_row_selector tks_checker u_tks_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_stall     (i_stall),
    .i_out_key   (o_out_key),
    .i_out_rank  (o_out_rank),
    .i_out_last  (o_out_last),
    .i_none_kept (o_none_kept)
);

>>> sim/top_k_row_selector_checker.sv
// Watches the top-k selector's channels, predicts each flush's results and compares them.
module top_k_row_selector_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [tks_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tks_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic                               i_cmd,
    input  logic [tks_pkg::KEY_PORT_W-1:0]     i_row_key,
    input  logic [tks_pkg::TAG_PORT_W-1:0]     i_row_tag,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [tks_pkg::KEY_PORT_W-1:0]     i_out_key,
    input  logic [tks_pkg::TAG_PORT_W-1:0]     i_out_tag,
    input  logic [tks_pkg::RANK_W-1:0]         i_out_rank,
    input  logic                               i_out_last,
    input  logic                               i_none_kept,
    output int                                 o_error_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [tks_pkg::KEY_PORT_W-1:0] key;
        logic [tks_pkg::TAG_PORT_W-1:0] tag;
        logic [tks_pkg::RANK_W-1:0]     rank;
        logic                           last;
        logic                           none;
    } t_emit_row;

    logic [tks_pkg::KEY_PORT_W-1:0] kept_key [DEPTH];
    logic [tks_pkg::TAG_PORT_W-1:0] kept_tag [DEPTH];
    int                             kept_n;
    logic                           descending;
    logic [tks_pkg::LIMIT_W-1:0]    limit_reg;
    t_emit_row                      rows_due [$];

    function automatic bit outranks(logic [tks_pkg::KEY_PORT_W-1:0] a,
                                    logic [tks_pkg::KEY_PORT_W-1:0] b);
        return descending ? (a > b) : (a < b);
    endfunction

    // limit 0 behaves as 1, anything above the depth as the depth
    function automatic int clamped_limit();
        int lim;
        lim = int'(limit_reg);
        if (lim < 1) lim = 1;
        if (lim > DEPTH) lim = DEPTH;
        return lim;
    endfunction

    function automatic void insert_row(logic [tks_pkg::KEY_PORT_W-1:0] key,
                                       logic [tks_pkg::TAG_PORT_W-1:0] tag);
        int n;
        int pos;
        n = kept_n;
        if (n >= clamped_limit()) begin
            if (!outranks(key, kept_key[n-1])) return;
            n--;
        end
        pos = n;
        for (int i = 0; i < n; i++) begin
            if (outranks(key, kept_key[i])) begin
                pos = i;
                break;
            end
        end
        for (int i = n; i > pos; i--) begin
            kept_key[i] = kept_key[i-1];
            kept_tag[i] = kept_tag[i-1];
        end
        kept_key[pos] = key;
        kept_tag[pos] = tag;
        kept_n = n + 1;
    endfunction

    function automatic void drain_kept_rows();
        int n;
        t_emit_row r;
        n = (kept_n > clamped_limit()) ? clamped_limit() : kept_n;
        kept_n = 0;
        if (n == 0) begin
            r = '{key: '0, tag: '0, rank: '0, last: 1'b1, none: 1'b1};
            rows_due = {rows_due, r};
            return;
        end
        for (int i = 0; i < n; i++) begin
            r.key  = kept_key[i];
            r.tag  = kept_tag[i];
            r.rank = tks_pkg::RANK_W'(i);
            r.last = (i == n - 1);
            r.none = 1'b0;
            rows_due = {rows_due, r};
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_emit_row got;
        t_emit_row want;
        if (!i_rst_n) begin
            kept_n        = 0;
            descending    = 1'b0;
            limit_reg     = tks_pkg::LIMIT_RST;
            o_error_count = 0;
            rows_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{key: i_out_key, tag: i_out_tag, rank: i_out_rank,
                        last: i_out_last, none: i_none_kept};
                if (rows_due.size() == 0) begin
                    if (o_error_count < 10)
                        $display("%0t: unexpected result key=%h tag=%h rank=%0d last=%0b none=%0b",
                                 $realtime, got.key, got.tag, got.rank, got.last, got.none);
                    o_error_count++;
                end else begin
                    want = rows_due.pop_front();
                    if (got !== want) begin
                        if (o_error_count < 10)
                            $display({"%0t: result mismatch\n",
                                      "  expected key=%h tag=%h rank=%0d last=%0b none=%0b\n",
                                      "  actual   key=%h tag=%h rank=%0d last=%0b none=%0b"},
                                     $realtime, want.key, want.tag, want.rank, want.last,
                                     want.none, got.key, got.tag, got.rank, got.last, got.none);
                        o_error_count++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    tks_pkg::REG_SORT_DESC:  descending = i_cfg_data[0];
                    tks_pkg::REG_KEEP_LIMIT: limit_reg  = i_cfg_data[tks_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == tks_pkg::CMD_FLUSH)
                    drain_kept_rows();
                else
                    insert_row(i_row_key, i_row_tag);
            end
        end
        o_pending = rows_due.size();
    end

endmodule

>>> sim/testbench.sv
// Top of the top-k selector testbench: clock, reset, request stimulus, receiver stalls, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        RX_FLOW,
        RX_SPARSE,
        RX_DENSE,
        RX_TOGGLE
    } t_rx_mode;

    localparam int RANDOM_ITEMS = 260;
    localparam int SETTLE_CYCLES = 24;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [tks_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [tks_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                             i_valid;
    logic                             o_stall;
    logic                             i_cmd;
    logic [tks_pkg::KEY_PORT_W-1:0]   i_row_key;
    logic [tks_pkg::TAG_PORT_W-1:0]   i_row_tag;
    logic                             o_valid;
    logic                             i_stall;
    logic [tks_pkg::KEY_PORT_W-1:0]   o_out_key;
    logic [tks_pkg::TAG_PORT_W-1:0]   o_out_tag;
    logic [tks_pkg::RANK_W-1:0]       o_out_rank;
    logic                             o_out_last;
    logic                             o_none_kept;

    int error_count;
    int rows_pending;
    int burst_left;
    int random_items;
    bit long_hold_req;
    bit long_hold_done;

    top_k_row_selector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_row_key   (i_row_key),
        .i_row_tag   (i_row_tag),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_key   (o_out_key),
        .o_out_tag   (o_out_tag),
        .o_out_rank  (o_out_rank),
        .o_out_last  (o_out_last),
        .o_none_kept (o_none_kept)
    );

    top_k_row_selector_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_cmd         (i_cmd),
        .i_row_key     (i_row_key),
        .i_row_tag     (i_row_tag),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_key     (o_out_key),
        .i_out_tag     (o_out_tag),
        .i_out_rank    (o_out_rank),
        .i_out_last    (o_out_last),
        .i_none_kept   (o_none_kept),
        .o_error_count (error_count),
        .o_pending     (rows_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("top_k_row_selector verification failed");
        $finish;
    end

    // receiver: random stall modes, plus one long hold-off on request
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       hold_left;
        i_stall   = 1'b0;
        rx_mode   = RX_FLOW;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (rx_mode)
                    RX_FLOW:   i_stall <= 1'b0;
                    RX_SPARSE: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_DENSE:  i_stall <= ($urandom_range(0, 3) != 0);
                    default:   i_stall <= ~i_stall;
                endcase
            end
        end
    end

    function automatic logic [tks_pkg::KEY_PORT_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            // narrow range gives ties
            2, 3, 4: return tks_pkg::KEY_PORT_W'($urandom_range(0, 15));
            5:       return {60'hFFF_FFFF_FFFF_FFFF, 4'($urandom_range(0, 15))};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [tks_pkg::TAG_PORT_W-1:0] pick_tag();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [tks_pkg::LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd31;
            4:       return 5'($urandom_range(17, 30));
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    // random bursts with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_request(logic cmd, logic [tks_pkg::KEY_PORT_W-1:0] key,
                                logic [tks_pkg::TAG_PORT_W-1:0] tag);
        bit taken;
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_row_key <= key;
        i_row_tag <= tag;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        pace();
    endtask

    task automatic offer(logic [tks_pkg::KEY_PORT_W-1:0] key,
                         logic [tks_pkg::TAG_PORT_W-1:0] tag);
        send_request(tks_pkg::CMD_OFFER, key, tag);
    endtask

    // key and tag are don't-care on a flush, so drive noise there
    task automatic flush();
        send_request(tks_pkg::CMD_FLUSH, {$urandom(), $urandom()}, $urandom());
    endtask

    // only while idle: no result outstanding, then let any drain finish
    task automatic set_register(logic [tks_pkg::CFG_IDX_W-1:0] idx,
                                logic [tks_pkg::CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (rows_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_order(logic desc);
        // upper data bits are ignored for this register
        set_register(tks_pkg::REG_SORT_DESC, {4'($urandom_range(0, 15)), desc});
    endtask

    task automatic set_limit(logic [tks_pkg::LIMIT_W-1:0] lim);
        set_register(tks_pkg::REG_KEEP_LIMIT, lim);
    endtask

    initial begin
        int n_offers;
        int cut;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_cmd          = tks_pkg::CMD_OFFER;
        i_row_key      = '0;
        i_row_tag      = '0;
        burst_left     = 0;
        random_items   = 0;
        long_hold_req  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty flush, extremes and ties at reset config
        flush();
        offer('0, '1);
        offer('1, '0);
        offer(64'd5, 32'd1);
        offer(64'd5, 32'd2);
        offer(64'd5, 32'd3);
        flush();

        // descending, limit 2: equal key that is not strictly better is dropped
        set_order(1'b1);
        set_limit(5'd2);
        offer(64'd7, 32'hA);
        offer(64'd9, 32'hB);
        offer(64'd9, 32'hC);
        offer(64'd9, 32'hD);
        offer('1, 32'hE);
        flush();

        // limit 0 acts as 1
        set_order(1'b0);
        set_limit(5'd0);
        offer(64'd3, 32'h1);
        offer(64'd2, 32'h2);
        flush();

        // limit lowered and direction flipped while rows are kept
        set_limit(5'd31);
        offer(64'd40, 32'h10);
        offer(64'd10, 32'h11);
        offer(64'd30, 32'h12);
        offer(64'd20, 32'h13);
        set_limit(5'd2);
        offer(64'd15, 32'h14);
        set_order(1'b1);
        offer(64'd50, 32'h15);
        flush();

        // random: offer runs closed by a flush, configs changed between and inside runs
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 1)) set_order(1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1)) set_limit(pick_limit());
            end
            n_offers = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 24)
                                                   : $urandom_range(0, 12);
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_offers) : -1;
            for (int i = 0; i < n_offers; i++) begin
                if (i == cut) begin
                    if ($urandom_range(0, 1)) set_order(1'($urandom_range(0, 1)));
                    else set_limit(pick_limit());
                end
                offer(pick_key(), pick_tag());
                random_items++;
            end
            // hold the receiver off once while the sender keeps pushing
            if (random_items > 100 && !long_hold_req) long_hold_req = 1'b1;
            flush();
            random_items++;
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (rows_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("top_k_row_selector verification clean");
        else
            $display("top_k_row_selector verification failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tks_pkg.sv
hw/rtl/tks_cell.sv
hw/rtl/top_k_row_selector.sv
hw/rtl/tks_checker.sv
sim/top_k_row_selector_checker.sv
sim/testbench.sv
